// ===== hw/rtl/heading_circular_mean_filter_core_defines.svh =====
// Assertion macros for the heading filter.
`ifndef HEADING_CIRCULAR_MEAN_FILTER_CORE_DEFINES_SVH
`define HEADING_CIRCULAR_MEAN_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HCMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heading filter check failed");
`define HCMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heading filter check failed");
`else
`define HCMF_ASSERT_NOW(label, ante, cons)
`define HCMF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/hcmf_pkg.sv =====
package hcmf_pkg;

  localparam int RAW_W        = 16;
  localparam int ANG_W        = 13;
  localparam int Q15_W        = 16;
  localparam int Z_W          = 32;
  localparam int HALF_TURN    = 2880;
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;
  localparam int INV_GAIN_Q29 = 326016437;
  localparam int DEF_WINDOW_LEN   = 5;
  localparam int DEF_CORDIC_STEPS = 16;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 32'sd47185920;
      5'd1:  v = 32'sd27855475;
      5'd2:  v = 32'sd14718068;
      5'd3:  v = 32'sd7471121;
      5'd4:  v = 32'sd3750058;
      5'd5:  v = 32'sd1876857;
      5'd6:  v = 32'sd938658;
      5'd7:  v = 32'sd469357;
      5'd8:  v = 32'sd234682;
      5'd9:  v = 32'sd117342;
      5'd10: v = 32'sd58671;
      5'd11: v = 32'sd29335;
      5'd12: v = 32'sd14668;
      5'd13: v = 32'sd7334;
      5'd14: v = 32'sd3667;
      5'd15: v = 32'sd1833;
      5'd16: v = 32'sd917;
      5'd17: v = 32'sd458;
      5'd18: v = 32'sd229;
      5'd19: v = 32'sd115;
      5'd20: v = 32'sd57;
      5'd21: v = 32'sd29;
      5'd22: v = 32'sd14;
      5'd23: v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/hcmf_window.sv =====
module hcmf_window
  import hcmf_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [IDX_W-1:0]        waddr,
  input  logic signed [ANG_W-1:0] wdata,
  input  logic [IDX_W-1:0]        raddr,
  output logic signed [ANG_W-1:0] rdata
);

  logic signed [ANG_W-1:0] mem [WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hcmf_cordic.sv =====
module hcmf_cordic
  import hcmf_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
  parameter int XY_W         = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cordic_ctrl_t           ctrl,
  input  logic signed [XY_W-1:0] x0,
  input  logic signed [XY_W-1:0] y0,
  input  logic signed [Z_W-1:0]  z0,
  output logic signed [XY_W-1:0] x,
  output logic signed [XY_W-1:0] y,
  output logic signed [Z_W-1:0]  z,
  output logic                   done
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  logic              busy;
  logic              vec;
  logic [ITER_W-1:0] iter;
  logic              pos_rot;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  ang;

  always_comb begin
    xs      = x >>> iter;
    ys      = y >>> iter;
    ang     = atan_lut(5'(iter));
    pos_rot = vec ? !(y > 0) : (z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
      vec  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        x    <= x0;
        y    <= y0;
        z    <= z0;
        vec  <= ctrl.vectoring;
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (pos_rot) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ang;
        end
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/heading_circular_mean_filter_core.sv =====
// Heading filter: one result per input item. A rejected read, a zero command or the first
// sample passes to the result register without using the CORDIC unit. A filtered sample
// first wraps its offset difference into the half-turn range one turn at a time, then runs
// the single shared CORDIC unit once per window entry (the window fill, up to WINDOW_LEN)
// and once more for atan2 unless both sums are zero. A result held back by the receiver
// keeps the next result waiting in S_DONE until it is taken. The window sits in a
// one-port-write, one-port-read memory.
module heading_circular_mean_filter_core
  import hcmf_pkg::*;
#(
  parameter int WINDOW_LEN   = DEF_WINDOW_LEN,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic signed [RAW_W-1:0] heading_raw,
  input  logic                    read_ok,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] rel_heading,
  output logic                    valid_res
);

  `include "heading_circular_mean_filter_core_defines.svh"

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W = Q15_W + CNT_W;
  localparam int XY_W  = (SUM_W + 13 > 32) ? SUM_W + 13 : 32;
  localparam int D_W   = RAW_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WRAP, S_READ, S_LOAD, S_ROT, S_VEC_START, S_VEC, S_DONE
  } state_t;

  state_t state;
  logic   sensor_ready;
  logic   offset_held;
  logic signed [RAW_W-1:0] heading_offset;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] write_slot;
  logic [CNT_W-1:0] rd_idx;
  logic signed [D_W-1:0]   diff;
  logic signed [SUM_W-1:0] sum_s, sum_c;
  logic neg;
  logic signed [ANG_W-1:0] res_ang;
  logic res_valid;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [ANG_W-1:0] mem_wdata;
  logic signed [ANG_W-1:0] mem_rdata;

  cordic_ctrl_t            cctrl;
  logic signed [XY_W-1:0]  cx0, cy0, cx, cy;
  logic signed [Z_W-1:0]   cz0, cz;
  logic                    cdone;

  logic                    accept;
  logic                    in_range;
  logic signed [ANG_W-1:0] fold_ang;
  logic                    fold_neg;
  logic signed [XY_W-1:0]  xf, yf, xq, yq;
  logic signed [SUM_W-1:0] q_c, q_s;
  logic signed [XY_W-1:0]  c_ext, s_ext;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [RAW_W-1:0] z_ang, z_wrap;
  logic [CNT_W-1:0]        slot_next;
  logic [CNT_W-1:0]        fill_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = (diff <= D_W'(HALF_TURN)) && (diff >= -D_W'(HALF_TURN));

  assign slot_next = (write_slot == CNT_W'(WINDOW_LEN - 1)) ? '0 : write_slot + 1'b1;
  assign fill_next = (fill_count == CNT_W'(WINDOW_LEN)) ? fill_count : fill_count + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_slot[IDX_W-1:0];
    mem_wdata = diff[ANG_W-1:0];
    if (state == S_IDLE && accept && sensor_ready && read_ok && (func || !offset_held)) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if (state == S_WRAP && in_range) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    fold_ang = mem_rdata;
    fold_neg = 1'b0;
    if (mem_rdata > ANG_W'(QUARTER_TURN)) begin
      fold_ang = mem_rdata - ANG_W'(HALF_TURN);
      fold_neg = 1'b1;
    end else if (mem_rdata < -ANG_W'(QUARTER_TURN)) begin
      fold_ang = mem_rdata + ANG_W'(HALF_TURN);
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    c_ext = XY_W'(sum_c) <<< 10;
    s_ext = XY_W'(sum_s) <<< 10;
    cctrl.start     = 1'b0;
    cctrl.vectoring = 1'b0;
    cx0 = XY_W'(INV_GAIN_Q29);
    cy0 = '0;
    cz0 = Z_W'(fold_ang) <<< 16;
    if (state == S_LOAD) begin
      cctrl.start = 1'b1;
    end else if (state == S_VEC_START) begin
      cctrl.start     = (sum_s != '0) || (sum_c != '0);
      cctrl.vectoring = 1'b1;
      cx0 = c_ext;
      cy0 = s_ext;
      cz0 = '0;
      if (sum_c < 0) begin
        cx0 = -c_ext;
        cy0 = -s_ext;
        cz0 = (sum_s >= 0) ? (Z_W'(HALF_TURN) <<< 16) : -(Z_W'(HALF_TURN) <<< 16);
      end
    end
  end

  always_comb begin
    xf = neg ? -cx : cx;
    yf = neg ? -cy : cy;
    xq = (xf + XY_W'(8192)) >>> 14;
    yq = (yf + XY_W'(8192)) >>> 14;
    if (xq > XY_W'(32767)) begin
      q_c = SUM_W'(32767);
    end else if (xq < -XY_W'(32768)) begin
      q_c = -SUM_W'(32768);
    end else begin
      q_c = xq[SUM_W-1:0];
    end
    if (yq > XY_W'(32767)) begin
      q_s = SUM_W'(32767);
    end else if (yq < -XY_W'(32768)) begin
      q_s = -SUM_W'(32768);
    end else begin
      q_s = yq[SUM_W-1:0];
    end
    z_rnd = (cz + Z_W'(32768)) >>> 16;
    z_ang = z_rnd[RAW_W-1:0];
    if (z_ang > RAW_W'(HALF_TURN)) begin
      z_wrap = z_ang - RAW_W'(FULL_TURN);
    end else if (z_ang < -RAW_W'(HALF_TURN)) begin
      z_wrap = z_ang + RAW_W'(FULL_TURN);
    end else begin
      z_wrap = z_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sensor_ready   <= 1'b0;
      offset_held    <= 1'b0;
      heading_offset <= '0;
      fill_count     <= '0;
      write_slot     <= '0;
      rd_idx         <= '0;
      out_valid      <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        sensor_ready <= cfg_wdata;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_ang   <= '0;
            res_valid <= 1'b0;
            state     <= S_DONE;
            if (sensor_ready && read_ok) begin
              if (func || !offset_held) begin
                heading_offset <= heading_raw;
                offset_held    <= 1'b1;
                write_slot     <= CNT_W'(1) % CNT_W'(WINDOW_LEN);
                fill_count     <= CNT_W'(1);
                res_valid      <= !func;
              end else begin
                diff  <= D_W'(heading_raw) - D_W'(heading_offset);
                state <= S_WRAP;
              end
            end
          end
        end
        S_WRAP: begin
          if (diff > D_W'(HALF_TURN)) begin
            diff <= diff - D_W'(FULL_TURN);
          end else if (diff < -D_W'(HALF_TURN)) begin
            diff <= diff + D_W'(FULL_TURN);
          end else begin
            write_slot <= slot_next;
            fill_count <= fill_next;
            rd_idx     <= '0;
            sum_s      <= '0;
            sum_c      <= '0;
            state      <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          neg   <= fold_neg;
          state <= S_ROT;
        end
        S_ROT: begin
          if (cdone) begin
            sum_s  <= sum_s + q_s;
            sum_c  <= sum_c + q_c;
            rd_idx <= rd_idx + 1'b1;
            state  <= (rd_idx + 1'b1 == fill_count) ? S_VEC_START : S_READ;
          end
        end
        S_VEC_START: begin
          res_valid <= 1'b1;
          res_ang   <= '0;
          state     <= cctrl.start ? S_VEC : S_DONE;
        end
        S_VEC: begin
          if (cdone) begin
            res_ang <= z_wrap[ANG_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            rel_heading <= res_ang;
            valid_res   <= res_valid;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hcmf_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .IDX_W      (IDX_W)
  ) u_window (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  hcmf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .XY_W         (XY_W)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cctrl),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .x    (cx),
    .y    (cy),
    .z    (cz),
    .done (cdone)
  );

  `HCMF_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CNT_W'(WINDOW_LEN))
  `HCMF_ASSERT_NOW(a_slot_bound, 1'b1, write_slot < CNT_W'(WINDOW_LEN))
  `HCMF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `HCMF_ASSERT_NOW(a_valid_needs_offset, out_valid && valid_res, offset_held)

endmodule

// ===== sim/tb_heading_circular_mean_filter_core.sv =====
module tb_heading_circular_mean_filter_core;
  import hcmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_SAMPLE = 1'b0;
  localparam logic FN_ZERO   = 1'b1;
  localparam int   NSTEPS    = DEF_CORDIC_STEPS;
  localparam int   WLEN      = DEF_WINDOW_LEN;
  localparam int   SETTLE    = 200;

  typedef struct {
    logic                    fn;
    logic signed [RAW_W-1:0] raw;
    logic                    ok;
  } heading_item_t;

  typedef struct {
    logic signed [ANG_W-1:0] ang;
    logic                    vld;
  } heading_res_t;

  localparam longint ARCTAN [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic signed [RAW_W-1:0] heading_raw = '0;
  logic read_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ANG_W-1:0] rel_heading;
  logic valid_res;

  heading_item_t pending_items[$];
  heading_item_t cur_item;
  heading_res_t  expected_headings[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  logic ready_reg = 1'b0;
  int   window_ang [WLEN];
  int   wr_slot = 0;
  int   filled = 0;
  int   ref_offset = 0;
  logic offset_taken = 1'b0;

  heading_circular_mean_filter_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .heading_raw(heading_raw), .read_ok(read_ok), .out_valid(out_valid),
    .out_ready(out_ready), .rel_heading(rel_heading), .valid_res(valid_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int wrap_turn(int d);
    while (d > HALF_TURN) d -= FULL_TURN;
    while (d < -HALF_TURN) d += FULL_TURN;
    return d;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void rotate_sincos(input int a, output longint s, output longint c);
    logic   flip;
    longint x, y, z, nx;
    flip = 1'b0;
    x = INV_GAIN_Q29;
    y = 0;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    z = longint'(a) * 65536;
    for (int i = 0; i < NSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_q15(x);
    s = round_q15(y);
  endfunction

  function automatic int mean_angle(longint s, longint c);
    longint x, y, z, nx;
    z = 0;
    if (s == 0 && c == 0) return 0;
    x = c * 1024;
    y = s * 1024;
    if (c < 0) begin
      z = (s >= 0) ? longint'(HALF_TURN) * 65536 : -longint'(HALF_TURN) * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end
      x = nx;
    end
    return wrap_turn(int'((z + 32768) >>> 16));
  endfunction

  function automatic void push_angle(int a);
    window_ang[wr_slot] = a;
    wr_slot = (wr_slot + 1) % WLEN;
    if (filled < WLEN) filled++;
  endfunction

  function automatic void take_offset(int raw);
    ref_offset = raw;
    offset_taken = 1'b1;
    foreach (window_ang[i]) window_ang[i] = 0;
    wr_slot = 0;
    filled = 0;
    push_angle(0);
  endfunction

  function automatic heading_res_t filter_heading(heading_item_t it);
    heading_res_t r;
    longint sum_s, sum_c, sv, cv;
    r.ang = '0;
    r.vld = 1'b0;
    sum_s = 0;
    sum_c = 0;
    if (ready_reg && it.ok) begin
      if (it.fn == FN_ZERO) begin
        take_offset(int'(it.raw));
      end else if (!offset_taken) begin
        take_offset(int'(it.raw));
        r.vld = 1'b1;
      end else begin
        push_angle(wrap_turn(int'(it.raw) - ref_offset));
        for (int i = 0; i < filled; i++) begin
          rotate_sincos(window_ang[i], sv, cv);
          sum_s += sv;
          sum_c += cv;
        end
        r.ang = ANG_W'(mean_angle(sum_s, sum_c));
        r.vld = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_headings.push_back(filter_heading(cur_item));
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          func <= cur_item.fn;
          heading_raw <= cur_item.raw;
          read_ok <= cur_item.ok;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    heading_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_headings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected item: rel_heading=%0d valid_res=%0b", rel_heading, valid_res);
        end else begin
          want = expected_headings.pop_front();
          if (rel_heading !== want.ang || valid_res !== want.vld) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: rel_heading exp %0d got %0d, valid_res exp %0b got %0b",
                       want.ang, rel_heading, want.vld, valid_res);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_item(logic fn, int raw, logic ok);
    heading_item_t it;
    it.fn = fn;
    it.raw = RAW_W'(raw);
    it.ok = ok;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_headings.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ready(logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ready_reg = v;
  endtask

  task automatic add_random(int n);
    int base, cnt;
    while (n > 0) begin
      base = $urandom_range(65535) - 32768;
      if ($urandom_range(3) != 0) add_item(FN_ZERO, base, 1'b1);
      else add_item(1'($urandom_range(1)), $urandom_range(65535), 1'($urandom_range(1)));
      cnt = $urandom_range(14, 3);
      for (int k = 0; k < cnt; k++) begin
        case ($urandom_range(9))
          0: add_item(FN_SAMPLE, $urandom_range(65535), 1'b1);
          1: add_item(1'($urandom_range(1)), $urandom_range(65535), 1'b0);
          2: add_item(FN_SAMPLE, base + $urandom_range(11520) - 5760, 1'b1);
          default: add_item(FN_SAMPLE, base + $urandom_range(1440) - 720, 1'b1);
        endcase
      end
      n -= cnt + 1;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_item(FN_SAMPLE, 100, 1'b1);
    add_item(FN_ZERO, -32768, 1'b1);
    add_item(FN_SAMPLE, 32767, 1'b0);
    drain();
    set_ready(1'b1);

    add_item(FN_SAMPLE, 500, 1'b0);
    add_item(FN_SAMPLE, 0, 1'b1);
    add_item(FN_SAMPLE, 2880, 1'b1);
    add_item(FN_SAMPLE, 2880, 1'b1);
    add_item(FN_SAMPLE, -2880, 1'b1);
    add_item(FN_SAMPLE, 1440, 1'b1);
    add_item(FN_SAMPLE, -1441, 1'b1);
    add_item(FN_ZERO, 7, 1'b0);
    add_item(FN_ZERO, -32768, 1'b1);
    add_item(FN_SAMPLE, 32767, 1'b1);
    add_item(FN_SAMPLE, -32768, 1'b1);
    add_item(FN_SAMPLE, 0, 1'b1);
    add_item(FN_ZERO, 32767, 1'b1);
    add_item(FN_SAMPLE, -32768, 1'b1);
    add_item(FN_SAMPLE, 32767, 1'b1);
    add_item(FN_SAMPLE, 5760, 1'b1);
    add_item(FN_SAMPLE, -5761, 1'b1);
    add_item(FN_SAMPLE, 12345, 1'b1);
    drain();

    add_random(450);
    drain();
    send_idle_pct = 71;
    add_random(450);
    drain();

    set_ready(1'b0);
    add_random(20);
    drain();
    set_ready(1'b1);

    send_idle_pct = 0;
    recv_stall_pct = 71;
    add_random(450);
    drain();
    send_idle_pct = 22;
    recv_stall_pct = 22;
    add_random(450);
    drain();

    if (fail_count == 0 && expected_headings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
